### src/clipped_box_blur_3x3_defines.svh
// Assertion macros for the clipped 3x3 box blur.
// Depends on signals named clk and arst_n in the module that uses them.
`ifndef CLIPPED_BOX_BLUR_3X3_DEFINES_SVH
`define CLIPPED_BOX_BLUR_3X3_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CBB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define CBB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/cbb_pkg.sv
// Shared constants, codes and types of the clipped 3x3 box blur.
// No dependencies.
`default_nettype none
package cbb_pkg;

	localparam int CH_W             = 16;
	localparam int PIX_W            = 3 * CH_W;
	localparam int SUM_W            = 18;
	localparam int COL_W            = 3 * SUM_W;
	localparam int TOT_W            = 20;
	localparam int DIM_W            = 10;
	localparam int MAX_SIDE_DEFAULT = 512;
	localparam int DIM_DEFAULT      = 512;

	// Divisor codes: the in-bounds pixel count of a clipped window.
	localparam int DIV_W = 3;
	localparam logic [DIV_W-1:0] DIV_1 = 3'd0;
	localparam logic [DIV_W-1:0] DIV_2 = 3'd1;
	localparam logic [DIV_W-1:0] DIV_3 = 3'd2;
	localparam logic [DIV_W-1:0] DIV_4 = 3'd3;
	localparam logic [DIV_W-1:0] DIV_6 = 3'd4;
	localparam logic [DIV_W-1:0] DIV_9 = 3'd5;

	// Reciprocals for division by three and nine, scaled by 2^RECIP_SHIFT.
	localparam int RECIP_SHIFT = 21;
	localparam int RECIP_W     = 20;
	localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'((1 << RECIP_SHIFT) / 3);
	localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'((1 << RECIP_SHIFT) / 9);

	typedef struct packed {
		logic [TOT_W-1:0] tot_red;
		logic [TOT_W-1:0] tot_green;
		logic [TOT_W-1:0] tot_blue;
		logic [DIV_W-1:0] div_code;
		logic             frame_done;
	} cbb_sums_t;

endpackage
`default_nettype wire

### src/cbb_ifs.sv
// Stream interfaces of the clipped 3x3 box blur: configuration, pixels, results.
// Depends on cbb_pkg.
`default_nettype none
interface cbb_cfg_if import cbb_pkg::*;;
	logic             valid;
	logic             ready;
	logic [DIM_W-1:0] image_dim;
	modport source (output valid, output image_dim, input ready);
	modport sink (input valid, input image_dim, output ready);
endinterface

interface cbb_pix_if import cbb_pkg::*;;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] in_red;
	logic [CH_W-1:0] in_green;
	logic [CH_W-1:0] in_blue;
	modport source (output valid, output in_red, output in_green, output in_blue, input ready);
	modport sink (input valid, input in_red, input in_green, input in_blue, output ready);
endinterface

interface cbb_res_if import cbb_pkg::*;;
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] out_red;
	logic [CH_W-1:0] out_green;
	logic [CH_W-1:0] out_blue;
	logic            frame_done;
	modport source (output valid, output out_red, output out_green, output out_blue,
		output frame_done, input ready);
	modport sink (input valid, input out_red, input out_green, input out_blue,
		input frame_done, output ready);
endinterface
`default_nettype wire

### src/cbb_line_mem.sv
// Line memory holding the row below and the row two below, one entry per column.
// One write port, one read port with registered read data; depends on nothing.
`default_nettype none
module cbb_line_mem #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 96,
	parameter int AW    = 9
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### src/cbb_div.sv
// Divides the three window totals by the window count and holds the result word.
// Two pipeline stages and an output register; depends on cbb_pkg and cbb_res_if.
`default_nettype none
module cbb_div import cbb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  cbb_sums_t  sums,
	cbb_res_if.source  results
);

	localparam int PROD_W = TOT_W + RECIP_W;
	localparam int REM_W  = TOT_W + 4;

	logic             s1_v_q, s2_v_q, out_v_q;
	cbb_sums_t        sums_s1;
	logic [2:0][TOT_W-1:0] q0_s2, pre_s2;
	logic [DIV_W-1:0] code_s2;
	logic             fd_s2;
	logic [2:0][CH_W-1:0] res_q;
	logic             fd_q;

	logic             out_load, s2_load;
	logic [2:0][TOT_W-1:0] tot, q0_d, pre_d;
	logic [2:0][CH_W-1:0]  q_d;

	assign out_load = s2_v_q && (!out_v_q || results.ready);
	assign s2_load  = s1_v_q && (!s2_v_q || out_load);
	assign in_ready = !s1_v_q || s2_load;

	assign tot = {sums_s1.tot_red, sums_s1.tot_green, sums_s1.tot_blue};

	// Reciprocal multiply; the estimate is the true quotient or one below it.
	always_comb begin
		logic [RECIP_W-1:0] recip;
		logic [PROD_W-1:0]  prod;
		recip = (sums_s1.div_code == DIV_9) ? RECIP_9 : RECIP_3;
		for (int k = 0; k < 3; k++) begin
			pre_d[k] = (sums_s1.div_code == DIV_6) ? (tot[k] >> 1) : tot[k];
			prod = PROD_W'(pre_d[k]) * PROD_W'(recip);
			case (sums_s1.div_code)
				DIV_1:   q0_d[k] = tot[k];
				DIV_2:   q0_d[k] = tot[k] >> 1;
				DIV_4:   q0_d[k] = tot[k] >> 2;
				default: q0_d[k] = TOT_W'(prod >> RECIP_SHIFT);
			endcase
		end
	end

	// Correction: one compare of the remainder against the divisor.
	always_comb begin
		logic [REM_W-1:0] back, rem, dd;
		logic             exact;
		exact = (code_s2 == DIV_1) || (code_s2 == DIV_2) || (code_s2 == DIV_4);
		dd = (code_s2 == DIV_9) ? REM_W'(9) : REM_W'(3);
		for (int k = 0; k < 3; k++) begin
			if (code_s2 == DIV_9) begin
				back = (REM_W'(q0_s2[k]) << 3) + REM_W'(q0_s2[k]);
			end else begin
				back = (REM_W'(q0_s2[k]) << 1) + REM_W'(q0_s2[k]);
			end
			rem = REM_W'(pre_s2[k]) - back;
			if (!exact && rem >= dd) begin
				q_d[k] = CH_W'(q0_s2[k] + TOT_W'(1));
			end else begin
				q_d[k] = CH_W'(q0_s2[k]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				s1_v_q <= 1'b1;
			end else if (s2_load) begin
				s1_v_q <= 1'b0;
			end
			if (s2_load) begin
				s2_v_q <= 1'b1;
			end else if (out_load) begin
				s2_v_q <= 1'b0;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (results.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sums_s1 <= sums;
		end
		if (s2_load) begin
			q0_s2   <= q0_d;
			pre_s2  <= pre_d;
			code_s2 <= sums_s1.div_code;
			fd_s2   <= sums_s1.frame_done;
		end
		if (out_load) begin
			res_q <= q_d;
			fd_q  <= fd_s2;
		end
	end

	assign results.valid      = out_v_q;
	assign results.out_red    = res_q[2];
	assign results.out_green  = res_q[1];
	assign results.out_blue   = res_q[0];
	assign results.frame_done = fd_q;

endmodule
`default_nettype wire

### src/clipped_box_blur_3x3.sv
// Top level of the clipped 3x3 box blur: position tracking, window sums, line memory.
// Depends on cbb_pkg, cbb_ifs, cbb_line_mem, cbb_div and the assertion macro header.
`default_nettype none
`include "clipped_box_blur_3x3_defines.svh"

// Clipped 3x3 mean filter over a square RGB image with 16-bit channels. Pixels
// arrive in reverse raster order (bottom row first, right to left), and every
// pixel completes its own window, so each input word gives exactly one result
// word: the mean over rows i..i+2 and columns j..j+2 clipped to the image,
// divided by the in-bounds count with truncation. frame_done marks the result
// for pixel (0,0). After each accepted word the block waits while the line
// memory, which has a registered read port, presents the entry of the next
// column. A result word passes the window totals register, the reciprocal
// multiply stage and the output register, and the next pixel is taken while
// a finished result still waits. The line memory holds MAX_SIDE entries of
// two pixels each; it is not cleared after reset, as entries are only read
// once the current frame has written them. A write of image_dim restarts the
// frame; 0 is taken as 1 and values above MAX_SIDE as MAX_SIDE. The user
// must see that configuration is only written while the block is idle; the
// block does not enforce this, and is always ready.
module clipped_box_blur_3x3 import cbb_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEFAULT
) (
	input  logic     clk,
	input  logic     arst_n,
	cbb_cfg_if.sink  cfg,
	cbb_pix_if.sink  pixels,
	cbb_res_if.source results
);

	localparam int PW      = $clog2(MAX_SIDE);
	localparam int CW      = ((PW > DIM_W) ? PW : DIM_W) + 2;
	localparam int DIM_RST = (DIM_DEFAULT < MAX_SIDE) ? DIM_DEFAULT : MAX_SIDE;
	localparam int LINE_W  = 2 * PIX_W;

	// Registered state: the side length, the position of the next pixel, the
	// clipped column sums of the two columns to the right, and a one-cycle
	// wait flag while the memory read of a new column is in flight.
	logic [DIM_W-1:0] dim_q;
	logic [PW-1:0]    row_q, col_q;
	logic [COL_W-1:0] csn_q, csa_q;
	logic             busy_q;

	logic [LINE_W-1:0] line_rd;
	logic              div_ready;
	logic              accept;
	cbb_sums_t         sums;

	logic [CW-1:0]    dim_x, r_x, c_x;
	logic             have1, have2, next_ok, after_ok;
	logic             col_wrap, row_wrap;
	logic [PW-1:0]    dim_m1;
	logic [DIM_W-1:0] dim_new;
	logic [PW-1:0]    dim_new_m1;
	logic [1:0]       n_r, n_c;

	logic [2:0][CH_W-1:0]  pix_ch, rb_ch, rb2_ch;
	logic [2:0][SUM_W-1:0] here_ch, csn_ch, csa_ch;
	logic [2:0][TOT_W-1:0] tot_ch;

	assign accept       = pixels.valid && pixels.ready;
	assign pixels.ready = !busy_q && div_ready;
	assign cfg.ready    = 1'b1;

	// Clamp of a written side length.
	always_comb begin
		if (cfg.image_dim == '0) begin
			dim_new = DIM_W'(1);
		end else if (CW'(cfg.image_dim) > CW'(MAX_SIDE)) begin
			dim_new = DIM_W'(MAX_SIDE);
		end else begin
			dim_new = cfg.image_dim;
		end
	end
	assign dim_new_m1 = PW'(dim_new - DIM_W'(1));

	assign dim_x    = CW'(dim_q);
	assign r_x      = CW'(row_q);
	assign c_x      = CW'(col_q);
	assign dim_m1   = PW'(dim_q - DIM_W'(1));
	assign have1    = (r_x + CW'(1)) < dim_x;
	assign have2    = (r_x + CW'(2)) < dim_x;
	assign next_ok  = (c_x + CW'(1)) < dim_x;
	assign after_ok = (c_x + CW'(2)) < dim_x;
	assign col_wrap = (col_q == '0) || (c_x >= dim_x);
	assign row_wrap = (row_q == '0) || (r_x >= dim_x);

	// Channel views; index 2 is red, 0 is blue, as in the packed words.
	assign pix_ch = {pixels.in_red, pixels.in_green, pixels.in_blue};
	assign rb_ch  = line_rd[LINE_W-1:PIX_W];
	assign rb2_ch = line_rd[PIX_W-1:0];
	assign csn_ch = csn_q;
	assign csa_ch = csa_q;

	// The column sum at this pixel takes in the rows below that exist; the
	// window total adds the stored sums of the columns to the right that
	// lie inside the image. Stale sums at the right edge are masked here.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			here_ch[k] = SUM_W'(pix_ch[k])
				+ (have1 ? SUM_W'(rb_ch[k]) : '0)
				+ (have2 ? SUM_W'(rb2_ch[k]) : '0);
			tot_ch[k] = TOT_W'(here_ch[k])
				+ (next_ok ? TOT_W'(csn_ch[k]) : '0)
				+ (after_ok ? TOT_W'(csa_ch[k]) : '0);
		end
	end

	assign n_r = 2'd1 + {1'b0, have1} + {1'b0, have2};
	assign n_c = 2'd1 + {1'b0, next_ok} + {1'b0, after_ok};

	always_comb begin
		sums.tot_red    = tot_ch[2];
		sums.tot_green  = tot_ch[1];
		sums.tot_blue   = tot_ch[0];
		sums.frame_done = (row_q == '0) && (col_q == '0);
		case ({n_r, n_c})
			{2'd1, 2'd1}:                 sums.div_code = DIV_1;
			{2'd1, 2'd2}, {2'd2, 2'd1}:   sums.div_code = DIV_2;
			{2'd1, 2'd3}, {2'd3, 2'd1}:   sums.div_code = DIV_3;
			{2'd2, 2'd2}:                 sums.div_code = DIV_4;
			{2'd2, 2'd3}, {2'd3, 2'd2}:   sums.div_code = DIV_6;
			default:                      sums.div_code = DIV_9;
		endcase
	end

	// The memory is always read at the column of the next pixel. Each
	// accepted word pushes the row below down to two below and stores the
	// new pixel as the row below, at the same column.
	cbb_line_mem #(
		.DEPTH (MAX_SIDE),
		.WIDTH (LINE_W),
		.AW    (PW)
	) u_line_mem (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata ({pix_ch, rb_ch}),
		.raddr (col_q),
		.rdata (line_rd)
	);

	cbb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.in_ready (div_ready),
		.sums     (sums),
		.results  (results)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q  <= DIM_W'(DIM_RST);
			row_q  <= PW'(DIM_RST - 1);
			col_q  <= PW'(DIM_RST - 1);
			csn_q  <= '0;
			csa_q  <= '0;
			busy_q <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			dim_q  <= dim_new;
			row_q  <= dim_new_m1;
			col_q  <= dim_new_m1;
			csn_q  <= '0;
			csa_q  <= '0;
			busy_q <= 1'b1;
		end else if (accept) begin
			csa_q  <= csn_q;
			csn_q  <= here_ch;
			busy_q <= 1'b1;
			if (col_wrap) begin
				col_q <= dim_m1;
				row_q <= row_wrap ? dim_m1 : row_q - PW'(1);
			end else begin
				col_q <= col_q - PW'(1);
			end
		end else begin
			busy_q <= 1'b0;
		end
	end

	`CBB_ASSERT_NEXT(a_wait_after_accept, accept, !pixels.ready,
		"pixel accepted while the line memory read was still in flight")
	`CBB_ASSERT_NOW(a_col_in_image, 1'b1, c_x < dim_x,
		"column position outside the image")
	`CBB_ASSERT_NOW(a_row_in_image, 1'b1, r_x < dim_x,
		"row position outside the image")
	`CBB_ASSERT_NEXT(a_frame_wrap, accept && sums.frame_done && !cfg.valid,
		(row_q == $past(dim_m1)) && (col_q == $past(dim_m1)),
		"position did not wrap to the start of the next frame")

endmodule
`default_nettype wire
